// ===== rtl/shcp_pkg.sv =====
// ----------------------------------------------------------------------------
// shcp_pkg: serial hex command parser package
// Character codes, parser states, result codes and the hex digit map.
// ----------------------------------------------------------------------------
package shcp_pkg;

	localparam int CharW  = 8;
	localparam int AccW   = 32;
	localparam int GainW  = 16;

	// character codes
	localparam logic [CharW-1:0] CH_LF    = 8'd10;
	localparam logic [CharW-1:0] CH_CR    = 8'd13;
	localparam logic [CharW-1:0] CH_ESC   = 8'd27;
	localparam logic [CharW-1:0] CH_SPACE = 8'd32;
	localparam logic [CharW-1:0] CH_W     = 8'h77; // w
	localparam logic [CharW-1:0] CH_R     = 8'h72; // r
	localparam logic [CharW-1:0] CH_C     = 8'h63; // c
	localparam logic [CharW-1:0] CH_P     = 8'h70; // p
	localparam logic [CharW-1:0] CH_I     = 8'h69; // i
	localparam logic [CharW-1:0] CH_DLO   = 8'h64; // d
	localparam logic [CharW-1:0] CH_DHI   = 8'h44; // D

	// parser states, one-hot
	typedef enum logic [2:0] {
		ST_CMD  = 3'b001,
		ST_ADDR = 3'b010,
		ST_DATA = 3'b100
	} parse_state_t;

	typedef enum logic [1:0] {
		GW_NONE  = 2'd0,
		GW_PROP  = 2'd1,
		GW_INTEG = 2'd2
	} gain_write_t;

	typedef enum logic [2:0] {
		STS_NONE      = 3'd0,
		STS_ESCAPE    = 3'd1,
		STS_LINE_DONE = 3'd2,
		STS_DATA_OOR  = 3'd3,
		STS_ADDR_OOR  = 3'd4
	} status_t;

	// 0-9 -> 0-9, a-z/A-Z -> 10-35, anything else -> all ones
	function automatic logic [AccW-1:0] digit_of(input logic [CharW-1:0] c);
		logic [AccW-1:0] d;
		d = '1;
		if (c >= 8'h30 && c <= 8'h39)
			d = AccW'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h7a)
			d = AccW'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h5a)
			d = AccW'(c - 8'h37);
		return d;
	endfunction

endpackage

// ===== rtl/serial_hex_command_parser.sv =====
// ----------------------------------------------------------------------------
// serial_hex_command_parser
// Command-line parser over received characters, drives PI gain writes.
// ----------------------------------------------------------------------------
// One character goes in per transaction and exactly one result comes out per
// character, registered and valid in the cycle after it is accepted. The block takes a new character every clock
// cycle as long as the result register is empty or being drained in the same
// cycle; throughput is then one character per cycle. All parsing
// (state update, hex accumulate, range checks) happens in one combinational
// pass between the input handshake and the result register.
// Commands: w, r, c read a hex address, a space, then hex data; p and i read
// hex data only (address kept from before). CR or LF ends the line: address
// >= 0x10000 gives status 4, else data >= 0x10000 gives status 3, else status
// 2 and, for p or i, a gain write of the low 16 data bits. d / D clear / set
// the debug flag. ESC gives status 1 and returns to command state. Characters
// other than digits and letters accumulate as minus one, letters past f as 16-35; accumulators wrap at 32 bits.
// ----------------------------------------------------------------------------
module serial_hex_command_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [shcp_pkg::CharW-1:0]        rx_char,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        gain_write,
	output logic [shcp_pkg::GainW-1:0]        gain_value,
	output logic [2:0]                        status,
	output logic                              debug_enable
);

	shcp_pkg::parse_state_t        state_q, state_d;
	logic [shcp_pkg::CharW-1:0]    cmd_q, cmd_d;
	logic [shcp_pkg::AccW-1:0]     addr_q, addr_d;
	logic [shcp_pkg::AccW-1:0]     data_q, data_d;
	logic                          dbg_q, dbg_d;

	shcp_pkg::gain_write_t         gw_d, gw_q;
	shcp_pkg::status_t             sts_d, sts_q;
	logic [shcp_pkg::GainW-1:0]    gv_d, gv_q;
	logic                          out_valid_q;

	logic                          accept;
	logic [shcp_pkg::AccW-1:0]     digit;

	// result register frees up when empty or drained this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign digit    = shcp_pkg::digit_of(rx_char);

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		data_d  = data_q;
		dbg_d   = dbg_q;
		gw_d    = shcp_pkg::GW_NONE;
		gv_d    = '0;
		sts_d   = shcp_pkg::STS_NONE;

		if (rx_char inside {shcp_pkg::CH_CR, shcp_pkg::CH_LF}) begin
			// line end: check ranges, maybe write gain; accumulators kept
			state_d = shcp_pkg::ST_CMD;
			if (|addr_q[shcp_pkg::AccW-1:shcp_pkg::GainW]) begin
				sts_d = shcp_pkg::STS_ADDR_OOR;
			end else if (|data_q[shcp_pkg::AccW-1:shcp_pkg::GainW]) begin
				sts_d = shcp_pkg::STS_DATA_OOR;
			end else begin
				sts_d = shcp_pkg::STS_LINE_DONE;
				if (cmd_q == shcp_pkg::CH_P) begin
					gw_d = shcp_pkg::GW_PROP;
					gv_d = data_q[shcp_pkg::GainW-1:0];
				end else if (cmd_q == shcp_pkg::CH_I) begin
					gw_d = shcp_pkg::GW_INTEG;
					gv_d = data_q[shcp_pkg::GainW-1:0];
				end
			end
		end else if (rx_char == shcp_pkg::CH_ESC) begin
			state_d = shcp_pkg::ST_CMD;
			sts_d   = shcp_pkg::STS_ESCAPE;
		end else begin
			case (state_q)
				shcp_pkg::ST_CMD: begin
					cmd_d = rx_char;
					if (rx_char inside {shcp_pkg::CH_W, shcp_pkg::CH_R, shcp_pkg::CH_C}) begin
						state_d = shcp_pkg::ST_ADDR;
						addr_d  = '0;
						data_d  = '0;
					end else if (rx_char inside {shcp_pkg::CH_P, shcp_pkg::CH_I}) begin
						state_d = shcp_pkg::ST_DATA;
						data_d  = '0;
					end else if (rx_char == shcp_pkg::CH_DLO) begin
						dbg_d = 1'b0;
					end else if (rx_char == shcp_pkg::CH_DHI) begin
						dbg_d = 1'b1;
					end
				end
				shcp_pkg::ST_ADDR: begin
					if (rx_char == shcp_pkg::CH_SPACE)
						state_d = shcp_pkg::ST_DATA;
					else
						addr_d = {addr_q[shcp_pkg::AccW-5:0], 4'h0} + digit;
				end
				shcp_pkg::ST_DATA: begin
					data_d = {data_q[shcp_pkg::AccW-5:0], 4'h0} + digit;
				end
				default: begin
					// illegal code: recover to command state
					state_d = shcp_pkg::ST_CMD;
				end
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shcp_pkg::ST_CMD;
			cmd_q   <= '0;
			addr_q  <= '0;
			data_q  <= '0;
			dbg_q   <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
			addr_q  <= addr_d;
			data_q  <= data_d;
			dbg_q   <= dbg_d;
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			gw_q  <= gw_d;
			gv_q  <= gv_d;
			sts_q <= sts_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign gain_write   = gw_q;
	assign gain_value   = gv_q;
	assign status       = sts_q;
	assign debug_enable = dbg_q;

endmodule

// ===== test/tb_serial_hex_command_parser.sv =====
// ----------------------------------------------------------------------------
// tb_serial_hex_command_parser: self-checking bench for the command parser
// Feeds character streams (directed lines, then random well-formed and broken
// command lines) and checks every result against a cycle-free parser model.
// ----------------------------------------------------------------------------
module tb_serial_hex_command_parser;
	timeunit 1ns;
	timeprecision 1ps;

	// no transaction on either side for this long ends the run
	localparam int StallLimit = 1000;
	// accumulators at or above this fail the line-end range check
	localparam logic [31:0] RangeLimit = 32'h0001_0000;

	typedef struct {
		shcp_pkg::gain_write_t gw;
		logic [15:0]           gv;
		shcp_pkg::status_t     st;
		logic                  dbg;
	} parser_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_char = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  gain_write;
	logic [15:0] gain_value;
	logic [2:0]  status;
	logic        debug_enable;

	serial_hex_command_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_char      (rx_char),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gain_write   (gain_write),
		.gain_value   (gain_value),
		.status       (status),
		.debug_enable (debug_enable)
	);

	always #5 clk = ~clk;

	// characters waiting to be sent, results waiting to come back
	logic [7:0]     char_q[$];
	parser_result_t result_q[$];
	parser_result_t head_result;

	// pacing: percent of cycles each side holds off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int fail_count = 0;
	int idle_cycles = 0;

	// run statistics
	int n_chars = 0;
	int n_results = 0;
	int n_gain_writes = 0;
	int n_range_errs = 0;
	int n_escapes = 0;
	int n_line_done = 0;

	// shadow copy of the parser state
	shcp_pkg::parse_state_t pstate = shcp_pkg::ST_CMD;
	logic [7:0]   cmd_letter = 8'h00;
	logic [31:0]  addr_acc = '0;
	logic [31:0]  data_acc = '0;
	logic         dbg_flag = 1'b0;

	// hex weight of a character; letters run on past f up to z (35),
	// anything else counts as minus one
	function automatic logic [31:0] hex_weight(input logic [7:0] c);
		logic [31:0] w;
		w = '1;
		if (c >= "0" && c <= "9")
			w = 32'(c - "0");
		else if (c >= "a" && c <= "z")
			w = 32'(c - "a") + 32'd10;
		else if (c >= "A" && c <= "Z")
			w = 32'(c - "A") + 32'd10;
		return w;
	endfunction

	// advance the shadow parser by one character and queue its result
	task automatic parse_char(input logic [7:0] c);
		parser_result_t r;
		r.gw = shcp_pkg::GW_NONE;
		r.gv = '0;
		r.st = shcp_pkg::STS_NONE;
		if (c == shcp_pkg::CH_CR || c == shcp_pkg::CH_LF) begin
			// line end in any state: range check, then maybe a gain write;
			// accumulators and letter survive so a repeat does the same
			if (addr_acc >= RangeLimit) begin
				r.st = shcp_pkg::STS_ADDR_OOR;
				n_range_errs++;
			end else if (data_acc >= RangeLimit) begin
				r.st = shcp_pkg::STS_DATA_OOR;
				n_range_errs++;
			end else begin
				r.st = shcp_pkg::STS_LINE_DONE;
				n_line_done++;
				if (cmd_letter == shcp_pkg::CH_P) begin
					r.gw = shcp_pkg::GW_PROP;
					r.gv = data_acc[15:0];
					n_gain_writes++;
				end else if (cmd_letter == shcp_pkg::CH_I) begin
					r.gw = shcp_pkg::GW_INTEG;
					r.gv = data_acc[15:0];
					n_gain_writes++;
				end
			end
			pstate = shcp_pkg::ST_CMD;
		end else if (c == shcp_pkg::CH_ESC) begin
			// escape only resets the state, letter and accumulators stay
			r.st = shcp_pkg::STS_ESCAPE;
			pstate = shcp_pkg::ST_CMD;
			n_escapes++;
		end else begin
			case (pstate)
				shcp_pkg::ST_CMD: begin
					// any character is latched as the letter, unknown ones go no further
					cmd_letter = c;
					if (c == shcp_pkg::CH_W || c == shcp_pkg::CH_R || c == shcp_pkg::CH_C) begin
						pstate = shcp_pkg::ST_ADDR;
						addr_acc = '0;
						data_acc = '0;
					end
					if (c == shcp_pkg::CH_P || c == shcp_pkg::CH_I) begin
						// gain commands keep the old address
						pstate = shcp_pkg::ST_DATA;
						data_acc = '0;
					end
					if (c == shcp_pkg::CH_DLO)
						dbg_flag = 1'b0;
					if (c == shcp_pkg::CH_DHI)
						dbg_flag = 1'b1;
				end
				shcp_pkg::ST_ADDR: begin
					if (c == shcp_pkg::CH_SPACE)
						pstate = shcp_pkg::ST_DATA;
					else
						addr_acc = addr_acc * 32'd16 + hex_weight(c);
				end
				shcp_pkg::ST_DATA: begin
					// a space here is just another non-digit
					data_acc = data_acc * 32'd16 + hex_weight(c);
				end
				default: ;
			endcase
		end
		r.dbg = dbg_flag;
		result_q.push_back(r);
		n_chars++;
	endtask

	// ------------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------------
	task automatic push_text(input string s);
		foreach (s[k])
			char_q.push_back(s[k]);
	endtask

	// mostly real hex digits, sometimes letters past f or any byte at all
	function automatic logic [7:0] rand_digit();
		logic [7:0] d;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: d = 8'("0" + $urandom_range(9));
			5, 6:          d = 8'("a" + $urandom_range(5));
			7:             d = 8'("A" + $urandom_range(5));
			8:             d = $urandom_range(1) ? 8'("g" + $urandom_range(19))
			                                     : 8'("G" + $urandom_range(19));
			default:       d = 8'($urandom_range(255));
		endcase
		return d;
	endfunction

	// digit counts stay within four most of the time so lines pass the check
	task automatic push_digits();
		int n;
		n = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(4);
		repeat (n)
			char_q.push_back(rand_digit());
	endtask

	task automatic push_line_end();
		char_q.push_back($urandom_range(1) ? shcp_pkg::CH_CR : shcp_pkg::CH_LF);
	endtask

	// one random command line, well formed most of the time
	task automatic push_random_line();
		int k;
		k = $urandom_range(99);
		if (k < 35) begin
			// address command: letter, address, space, data, line end
			case ($urandom_range(2))
				0:       char_q.push_back(shcp_pkg::CH_W);
				1:       char_q.push_back(shcp_pkg::CH_R);
				default: char_q.push_back(shcp_pkg::CH_C);
			endcase
			push_digits();
			if ($urandom_range(9) != 0) begin
				char_q.push_back(shcp_pkg::CH_SPACE);
				push_digits();
			end
			push_line_end();
		end else if (k < 65) begin
			// gain command: letter, data, line end
			char_q.push_back($urandom_range(1) ? shcp_pkg::CH_P : shcp_pkg::CH_I);
			push_digits();
			push_line_end();
		end else if (k < 72) begin
			char_q.push_back($urandom_range(1) ? shcp_pkg::CH_DLO : shcp_pkg::CH_DHI);
		end else if (k < 80) begin
			// line cut short by escape
			char_q.push_back($urandom_range(1) ? shcp_pkg::CH_W : shcp_pkg::CH_P);
			push_digits();
			if ($urandom_range(1))
				char_q.push_back(shcp_pkg::CH_SPACE);
			char_q.push_back(shcp_pkg::CH_ESC);
		end else if (k < 88) begin
			// raw noise, any byte
			repeat ($urandom_range(1, 3))
				char_q.push_back(8'($urandom_range(255)));
		end else if (k < 94) begin
			// bare line ends repeat the last check
			repeat ($urandom_range(1, 2))
				push_line_end();
		end else begin
			// unterminated line, the next letter lands in the address or data
			char_q.push_back($urandom_range(1) ? shcp_pkg::CH_C : shcp_pkg::CH_I);
			push_digits();
		end
	endtask

	task automatic push_random_lines(input int target);
		int base;
		base = char_q.size();
		while (char_q.size() - base < target)
			push_random_line();
	endtask

	// hold the sender until every outstanding result has come back
	task automatic wait_drained();
		while (char_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// driver: one character per input transaction, valid held until taken
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_char  <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				parse_char(rx_char);
			// slot is free when nothing is pending or it is taken right now
			if (!in_valid || in_ready) begin
				if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_char  <= char_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: each output transaction is checked against the oldest result
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result gain_write=%0d gain_value=%h status=%0d dbg=%0d",
						$realtime, gain_write, gain_value, status, debug_enable);
					fail_count++;
				end else begin
					head_result = result_q.pop_front();
					if (gain_write !== head_result.gw) begin
						$display("%0t: gain_write expected %0d actual %0d",
							$realtime, head_result.gw, gain_write);
						fail_count++;
					end
					if (gain_value !== head_result.gv) begin
						$display("%0t: gain_value expected %h actual %h",
							$realtime, head_result.gv, gain_value);
						fail_count++;
					end
					if (status !== head_result.st) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, head_result.st, status);
						fail_count++;
					end
					if (debug_enable !== head_result.dbg) begin
						$display("%0t: debug_enable expected %0d actual %0d",
							$realtime, head_result.dbg, debug_enable);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: counts cycles without any transaction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
			$display("tb_serial_hex_command_parser NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// sequence: reset, directed lines, then three pacing phases
	// ------------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase 1: sender mostly busy, receiver mostly stalled
		send_idle_pct = 12;
		recv_idle_pct = 77;

		// debug set, proportional gain write, then a repeated line end
		char_q.push_back(shcp_pkg::CH_DHI);
		push_text("p1f");
		char_q.push_back(shcp_pkg::CH_CR);
		char_q.push_back(shcp_pkg::CH_LF);
		// spaces in data go in as minus one: data out of range
		push_text("c  ");
		char_q.push_back(shcp_pkg::CH_CR);
		// letters past f accumulate too: address out of range
		push_text("wz0000");
		char_q.push_back(shcp_pkg::CH_CR);
		// escape out of address entry, then an integral gain write
		char_q.push_back(shcp_pkg::CH_R);
		char_q.push_back(shcp_pkg::CH_ESC);
		push_text("iZ");
		char_q.push_back(shcp_pkg::CH_LF);
		// byte extremes as unknown commands, debug cleared
		char_q.push_back(8'h00);
		char_q.push_back(8'hFF);
		char_q.push_back(shcp_pkg::CH_DLO);

		push_random_lines(410);
		// sender stops here until every result is back
		wait_drained();

		// phase 2: the other way round
		send_idle_pct = 77;
		recv_idle_pct = 12;
		push_random_lines(440);
		wait_drained();

		// phase 3: full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_lines(440);
		wait_drained();

		// wait on a little to catch stray results
		repeat (4) @(posedge clk);
		if (result_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, result_q.size());
			fail_count++;
		end

		$display("covered %0d characters, %0d results: %0d lines done, %0d gain writes",
			n_chars, n_results, n_line_done, n_gain_writes);
		$display("  %0d range errors, %0d escapes, %0d mismatches",
			n_range_errs, n_escapes, fail_count);
		if (fail_count == 0)
			$display("tb_serial_hex_command_parser OK");
		else
			$display("tb_serial_hex_command_parser NOT OK");
		$finish;
	end

endmodule
